@@ sv/double_ended_priority_queue_macros.svh @@
// Assertion macros for the double-ended priority queue.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_MACROS_SVH

// check a condition in the same cycle
`define DEP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// check a condition in the next cycle
`define DEP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ sv/dep_pkg.sv @@
// Types and constants of the double-ended priority queue.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package dep_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_DEL_MAX = 2'd1;
  localparam logic [1:0] MODE_DEL_MIN = 2'd2;

  typedef logic signed [31:0] key_t;

  typedef struct packed {
    logic [1:0] mode;
    key_t       value;
  } in_item_t;

  typedef struct packed {
    key_t       max_key;
    key_t       min_key;
    logic [6:0] key_count;
    logic       is_empty;
    logic       dropped;
  } out_item_t;

  typedef struct packed {
    logic ins;
    logic del_min;
    key_t key;
  } cell_op_t;

endpackage

@@ sv/dep_cell.sv @@
// One cell of the sorted key chain: holds one key, trades with its neighbors.
// Depends on dep_pkg.
`timescale 1ns / 1ps
module dep_cell
  import dep_pkg::*;
(
  input  logic     clk,
  input  cell_op_t op,
  input  logic     occ,
  input  logic     left_shift,
  input  key_t     left_key,
  input  key_t     right_key,
  output logic     shift,
  output key_t     key
);

  // free cell or larger key: the new key lands here or further left
  assign shift = !occ || (key > op.key);

  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (left_shift) begin
        key <= left_key;
      end else if (shift) begin
        key <= op.key;
      end
    end else if (op.del_min) begin
      key <= right_key;
    end
  end

endmodule

@@ sv/double_ended_priority_queue.sv @@
// Double-ended priority queue: a sorted chain of dep_cell, ascending from cell 0.
// An accepted item's result is registered in pend, then in the result register; throughput
// one item per cycle while the result is not stalled, with compare and shift in all cells at once.
// Reset clears the count and the handshake state; keys are undefined until written,
// and no clearing pass runs, so items are taken from the first cycle after reset.
`timescale 1ns / 1ps
module double_ended_priority_queue
  import dep_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      request_valid,
  output logic      request_stall,
  input  in_item_t  request,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

`include "double_ended_priority_queue_macros.svh"

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pend;
  logic             pend_drop;
  logic             accept;
  logic             load;
  logic             full;
  logic             empty;
  logic             is_ins;
  logic             is_dmax;
  logic             is_dmin;
  cell_op_t         op;
  key_t             cell_key [CAPACITY];
  logic             shift    [CAPACITY];
  logic             occ      [CAPACITY];
  logic             last     [CAPACITY];
  key_t             max_sel;

  assign accept  = request_valid && !request_stall;
  assign full    = (count == CNT_W'(CAPACITY));
  assign empty   = (count == '0);
  assign is_ins  = (request.mode == MODE_INSERT);
  assign is_dmax = (request.mode == MODE_DEL_MAX);
  assign is_dmin = (request.mode == MODE_DEL_MIN);

  assign op.ins     = accept && is_ins && !full;
  assign op.del_min = accept && is_dmin && !empty;
  assign op.key     = request.value;

  assign load          = pend && (!result_valid || !result_stall);
  assign request_stall = pend && !load;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    key_t left_key;
    key_t right_key;
    logic left_shift;

    assign occ[g] = (count > CNT_W'(g));

    if (g == 0) begin : g_first
      assign left_shift = 1'b0;
      assign left_key   = cell_key[g];
    end else begin : g_mid
      assign left_shift = shift[g-1];
      assign left_key   = cell_key[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[g];
      assign last[g]   = occ[g];
    end else begin : g_inner
      assign right_key = cell_key[g+1];
      assign last[g]   = occ[g] && !occ[g+1];
    end

    dep_cell u_cell (
      .clk       (clk),
      .op        (op),
      .occ       (occ[g]),
      .left_shift(left_shift),
      .left_key  (left_key),
      .right_key (right_key),
      .shift     (shift[g]),
      .key       (cell_key[g])
    );
  end

  always_comb begin
    count_next = count;
    if (op.ins) begin
      count_next = count + CNT_W'(1);
    end else if (op.del_min || (accept && is_dmax && !empty)) begin
      count_next = count - CNT_W'(1);
    end
  end

  // the top occupied cell holds the maximum
  always_comb begin
    max_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (last[i]) begin
        max_sel = max_sel | cell_key[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_drop <= is_ins && full;
    end
    if (load) begin
      result.max_key   <= max_sel;
      result.min_key   <= empty ? key_t'(0) : cell_key[0];
      result.key_count <= 7'(count);
      result.is_empty  <= empty;
      result.dropped   <= pend_drop;
    end
  end

  `DEP_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY))
  `DEP_ASSERT_NEXT(a_insert_grows, op.ins, count == $past(count) + CNT_W'(1))
  `DEP_ASSERT_NEXT(a_delmax_keeps_min, accept && is_dmax && (count > CNT_W'(1)),
                   cell_key[0] == $past(cell_key[0]))
  `DEP_ASSERT_NOW(a_drop_when_full, pend && pend_drop, full)

endmodule

@@ tb/tb_double_ended_priority_queue.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_priority_queue: directed table, then random
// insert/delete traffic checked against a sorted-key predictor. Depends on dep_pkg.
module tb_double_ended_priority_queue;
  import dep_pkg::*;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int N_ROWS = 21;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [1:0] mode;
    key_t       value;
    logic       fixed;
    out_item_t  want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      request_valid;
  logic      request_stall;
  in_item_t  request;
  logic      result_valid;
  logic      result_stall;
  out_item_t result;

  key_t      sorted_keys[$];
  out_item_t pending_reports[$];
  out_item_t want;
  bit        gaps_on = 1'b1;
  bit        hold_req = 1'b0;
  int        mismatches = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        drops_seen = 0;
  int        peak_fill = 0;
  int        input_stalls = 0;
  int        mix_pcts [6] = '{80, 20, 60, 40, 90, 10};

  row_t directed_rows [0:N_ROWS-1] = '{
    '{MODE_DEL_MAX, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 7'd0, 1'b1, 1'b0}},
    '{MODE_DEL_MIN, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 7'd0, 1'b1, 1'b0}},
    '{MODE_NOP, 32'shFFFFFFFF, 1'b1, '{32'sd0, 32'sd0, 7'd0, 1'b1, 1'b0}},
    '{MODE_INSERT, 32'sh7FFFFFFF, 1'b1,
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 7'd1, 1'b0, 1'b0}},
    '{MODE_INSERT, 32'sh80000000, 1'b1,
      '{32'sh7FFFFFFF, 32'sh80000000, 7'd2, 1'b0, 1'b0}},
    '{MODE_INSERT, 32'sd0, 1'b1, '{32'sh7FFFFFFF, 32'sh80000000, 7'd3, 1'b0, 1'b0}},
    '{MODE_INSERT, -32'sd1, 1'b1, '{32'sh7FFFFFFF, 32'sh80000000, 7'd4, 1'b0, 1'b0}},
    '{MODE_INSERT, -32'sd1, 1'b1, '{32'sh7FFFFFFF, 32'sh80000000, 7'd5, 1'b0, 1'b0}},
    '{MODE_DEL_MAX, 32'sh55555555, 1'b1, '{32'sd0, 32'sh80000000, 7'd4, 1'b0, 1'b0}},
    '{MODE_DEL_MIN, 32'shAAAAAAAA, 1'b1, '{32'sd0, -32'sd1, 7'd3, 1'b0, 1'b0}},
    '{MODE_NOP, 32'sh55555555, 1'b1, '{32'sd0, -32'sd1, 7'd3, 1'b0, 1'b0}},
    '{MODE_DEL_MIN, 32'sd0, 1'b1, '{32'sd0, -32'sd1, 7'd2, 1'b0, 1'b0}},
    '{MODE_DEL_MIN, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 7'd1, 1'b0, 1'b0}},
    '{MODE_DEL_MAX, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 7'd0, 1'b1, 1'b0}},
    '{MODE_INSERT, 32'sd12345, 1'b0, '0},
    '{MODE_INSERT, -32'sd7, 1'b0, '0},
    '{MODE_INSERT, 32'sd12345, 1'b0, '0},
    '{MODE_DEL_MAX, 32'sd0, 1'b0, '0},
    '{MODE_DEL_MIN, 32'sd0, 1'b0, '0},
    '{MODE_DEL_MAX, 32'sd0, 1'b0, '0},
    '{MODE_DEL_MIN, 32'shAAAAAAAA, 1'b0, '0}
  };

  double_ended_priority_queue DUT (
    .clk(clk),
    .rst(rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request(request),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #4 clk = ~clk;

  function automatic out_item_t update_key_set(in_item_t it);
    out_item_t r;
    int pos;
    r = '0;
    case (it.mode)
      MODE_INSERT: begin
        if (sorted_keys.size() >= CAPACITY) begin
          r.dropped = 1'b1;
        end else begin
          pos = 0;
          while (pos < sorted_keys.size() && sorted_keys[pos] <= it.value) pos++;
          sorted_keys.insert(pos, it.value);
        end
      end
      MODE_DEL_MAX: if (sorted_keys.size() > 0) void'(sorted_keys.pop_back());
      MODE_DEL_MIN: if (sorted_keys.size() > 0) void'(sorted_keys.pop_front());
      default: ;
    endcase
    if (sorted_keys.size() == 0) begin
      r.is_empty = 1'b1;
    end else begin
      r.max_key = sorted_keys[sorted_keys.size() - 1];
      r.min_key = sorted_keys[0];
    end
    r.key_count = 7'(sorted_keys.size());
    return r;
  endfunction

  function automatic in_item_t random_item(int insert_pct);
    in_item_t it;
    it.value = key_t'($urandom);
    if ($urandom_range(0, 99) < 3) begin
      it.mode = MODE_NOP;
    end else if ($urandom_range(0, 99) < insert_pct) begin
      it.mode = MODE_INSERT;
    end else if ($urandom_range(0, 1) == 1) begin
      it.mode = MODE_DEL_MAX;
    end else begin
      it.mode = MODE_DEL_MIN;
    end
    case ($urandom_range(0, 3))
      1: it.value = key_t'(int'($urandom_range(0, 15)) - 8);
      2: begin
        case ($urandom_range(0, 3))
          0: it.value = 32'sh7FFFFFFF;
          1: it.value = 32'sh80000000;
          2: it.value = 32'sd0;
          default: it.value = -32'sd1;
        endcase
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic offer_item(in_item_t it, bit use_fixed, out_item_t fixed_want);
    out_item_t predicted;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      request_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    request_valid <= 1'b1;
    request <= it;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    predicted = update_key_set(it);
    items_sent++;
    if (predicted.dropped) drops_seen++;
    if (sorted_keys.size() > peak_fill) peak_fill = sorted_keys.size();
    pending_reports.push_back(use_fixed ? fixed_want : predicted);
  endtask

  task automatic pause_until_drained();
    request_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(string msg);
    if (mismatches < 100) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && request_valid && request_stall) input_stalls++;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_reports.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_reports.pop_front();
        if (result.max_key !== want.max_key)
          note_mismatch($sformatf("result %0d max_key %0d, expected %0d",
                                  results_seen, result.max_key, want.max_key));
        if (result.min_key !== want.min_key)
          note_mismatch($sformatf("result %0d min_key %0d, expected %0d",
                                  results_seen, result.min_key, want.min_key));
        if (result.key_count !== want.key_count)
          note_mismatch($sformatf("result %0d key_count %0d, expected %0d",
                                  results_seen, result.key_count, want.key_count));
        if (result.is_empty !== want.is_empty)
          note_mismatch($sformatf("result %0d is_empty %b, expected %b",
                                  results_seen, result.is_empty, want.is_empty));
        if (result.dropped !== want.dropped)
          note_mismatch($sformatf("result %0d dropped %b, expected %b",
                                  results_seen, result.dropped, want.dropped));
      end
    end
  end

  initial begin
    result_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        result_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    request_valid <= 1'b0;
    request <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      offer_item('{directed_rows[i].mode, directed_rows[i].value},
                 directed_rows[i].fixed, directed_rows[i].want);
    end
    pause_until_drained();

    repeat (300) offer_item(random_item(55), 1'b0, '0);

    // hold results back, which also stalls the input; the inserts that follow fill the queue past capacity
    hold_req = 1'b1;
    repeat (90) offer_item(random_item(100), 1'b0, '0);
    pause_until_drained();

    repeat (90) offer_item(random_item(0), 1'b0, '0);
    foreach (mix_pcts[k]) begin
      repeat (100) offer_item(random_item(mix_pcts[k]), 1'b0, '0);
    end

    gaps_on = 1'b0;
    repeat (150) offer_item(random_item(50), 1'b0, '0);

    pause_until_drained();
    repeat (20) @(posedge clk);

    $display("sent %0d items, checked %0d results, %0d full-queue drops, peak fill %0d",
             items_sent, results_seen, drops_seen, peak_fill);
    $display("input held off for %0d cycles, %0d mismatches", input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/dep_pkg.sv
sv/dep_cell.sv
sv/double_ended_priority_queue.sv
tb/tb_double_ended_priority_queue.sv
